FILE: rtl/spmv_pkg.sv
// Shared types and constants for the ELLPACK sparse matrix-vector core.
// Used by spmv_ctrl, spmv_datapath and the top level; depends on nothing.
package spmv_pkg;

  // Default sizes of the vector store and the arithmetic.
  localparam int VectorDepthDef = 1024;
  localparam int ValueWidthDef  = 32;

  // Fixed field widths of the ports and the internal registers.
  localparam int ColumnW   = 11;
  localparam int InValueW  = 32;
  localparam int RowIdxW   = 16;
  localparam int RowSumW   = 32;
  localparam int RowWidthW = 7;
  localparam int RowCountW = 17;
  localparam int SentinelW = 11;
  localparam int SlotW     = 6;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 17;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRowWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRowCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSentinel = 2'd2;

  // Input command codes.
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdSlot = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LL,
    ST_MUL_LH,
    ST_MUL_HL,
    ST_ACC
  } ctrl_state_e;

  // Which partial product the shared multiplier forms.
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     mul_step;
    mul_sel_e mul_sel;
    logic     acc_step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_slot;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: rtl/spmv_ctrl.sv
// Sequencer of the ELLPACK core: takes beats and steps the datapath through
// the partial products and the accumulate. Depends on spmv_pkg.
module spmv_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  spmv_pkg::ctrl_status_t status_i,
  output spmv_pkg::ctrl_cmd_t   cmd_o
);
  import spmv_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.capture   = 1'b0;
    cmd_o.mul_step  = 1'b0;
    cmd_o.mul_sel   = MUL_LL;
    cmd_o.acc_step  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i && status_i.in_is_slot) begin
          state_d = ST_MUL_LL;
        end
      end
      ST_MUL_LL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sel  = MUL_LL;
        state_d        = ST_MUL_LH;
      end
      ST_MUL_LH: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sel  = MUL_LH;
        state_d        = ST_MUL_HL;
      end
      ST_MUL_HL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sel  = MUL_HL;
        state_d        = ST_ACC;
      end
      ST_ACC: begin
        // Wait until the result register can take a possible result.
        if (status_i.out_free) begin
          cmd_o.acc_step = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A matrix slot always starts the multiply sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.capture && status_i.in_is_slot) |=> (state_q == ST_MUL_LL))
    else $error("slot beat did not start the multiply sequence");

  // The accumulate step only fires when the result register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_step |-> status_i.out_free)
    else $error("accumulate issued while the result register is held");

  // No new beat is taken while a slot is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!cmd_o.mul_step && !cmd_o.acc_step))
    else $error("input ready while the datapath is busy");

endmodule

FILE: rtl/spmv_datapath.sv
// Datapath of the ELLPACK core: vector store, shared half-width multiplier,
// row accumulator, row bookkeeping, registers and result register.
// Depends on spmv_pkg.
module spmv_datapath #(
  parameter int VECTOR_DEPTH = spmv_pkg::VectorDepthDef,
  parameter int VALUE_WIDTH  = spmv_pkg::ValueWidthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  spmv_pkg::ctrl_cmd_t                   cmd_i,
  output spmv_pkg::ctrl_status_t                status_o,
  input  logic                                  cfg_valid_i,
  input  logic [spmv_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [spmv_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                  command_i,
  input  logic signed [spmv_pkg::ColumnW-1:0]   column_i,
  input  logic signed [spmv_pkg::InValueW-1:0]  value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [spmv_pkg::RowIdxW-1:0]          row_index_o,
  output logic signed [spmv_pkg::RowSumW-1:0]   row_sum_o,
  output logic                                  last_row_o
);
  import spmv_pkg::*;

  localparam int AddrW = $clog2(VECTOR_DEPTH);
  localparam int HalfW = (VALUE_WIDTH + 1) / 2;

  // Configuration registers.
  logic [RowWidthW-1:0] row_width_q;
  logic [RowCountW-1:0] row_count_q;
  logic [SentinelW-1:0] sentinel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthW'(8);
      row_count_q <= RowCountW'(1);
      sentinel_q  <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRowWidth: row_width_q <= cfg_data_i[RowWidthW-1:0];
        CfgRowCount: row_count_q <= cfg_data_i[RowCountW-1:0];
        CfgSentinel: sentinel_q  <= cfg_data_i[SentinelW-1:0];
        default: ;
      endcase
    end
  end

  // Address decode of the incoming column.
  logic [31:0]      col_ext;
  logic             in_range;
  logic [AddrW-1:0] addr;

  assign col_ext  = {{(32 - ColumnW){1'b0}}, column_i};
  assign in_range = !column_i[ColumnW-1] && (col_ext < 32'(VECTOR_DEPTH));
  assign addr     = col_ext[AddrW-1:0];

  assign status_o.in_is_slot = (command_i == CmdSlot);

  // Vector store: one write port for loads, one registered read port for slots.
  logic [VALUE_WIDTH-1:0] mem [VECTOR_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && (command_i == CmdLoad) && in_range) begin
      mem[addr] <= VALUE_WIDTH'(value_i);
    end
    if (cmd_i.capture) begin
      rd_q <= mem[addr];
    end
  end

  // Slot operands captured with the beat.
  logic [VALUE_WIDTH-1:0] val_q;
  logic [ColumnW-1:0]     col_q;
  logic                   in_range_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_q      <= VALUE_WIDTH'(value_i);
      col_q      <= column_i;
      in_range_q <= in_range;
    end
  end

  // Shared half-width multiplier; the product wraps at VALUE_WIDTH bits, so
  // the high-by-high partial product never contributes.
  logic [HalfW-1:0]       op_a, op_b;
  logic [2*HalfW-1:0]     pp;
  logic [VALUE_WIDTH-1:0] product_q;

  always_comb begin
    op_a = val_q[HalfW-1:0];
    op_b = rd_q[HalfW-1:0];
    case (cmd_i.mul_sel)
      MUL_LH:  op_b = HalfW'(rd_q[VALUE_WIDTH-1:HalfW]);
      MUL_HL:  op_a = HalfW'(val_q[VALUE_WIDTH-1:HalfW]);
      default: ;
    endcase
  end

  assign pp = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      if (cmd_i.mul_sel == MUL_LL) begin
        product_q <= VALUE_WIDTH'(pp);
      end else begin
        product_q <= product_q + VALUE_WIDTH'({pp, {HalfW{1'b0}}});
      end
    end
  end

  // Effective last slot position and last row index after clamping.
  logic [SlotW-1:0]   last_pos;
  logic [RowIdxW-1:0] count_m1;

  always_comb begin
    if (row_width_q == '0) begin
      last_pos = '0;
    end else if (row_width_q > RowWidthW'(64)) begin
      last_pos = '1;
    end else begin
      last_pos = SlotW'(row_width_q - RowWidthW'(1));
    end
    if ((row_count_q == '0) || (row_count_q > RowCountW'(65536))) begin
      count_m1 = '1;
    end else begin
      count_m1 = RowIdxW'(row_count_q - RowCountW'(1));
    end
  end

  // Row state and the accumulate step.
  logic [VALUE_WIDTH-1:0] acc_q, acc_new;
  logic [SlotW-1:0]       slot_q;
  logic                   ended_q;
  logic [RowIdxW-1:0]     row_q;
  logic                   sentinel_hit, useful, row_done, emit;

  assign sentinel_hit = (col_q == sentinel_q);
  assign useful       = !ended_q && !sentinel_hit && in_range_q;
  assign acc_new      = useful ? (acc_q + product_q) : acc_q;
  assign row_done     = (slot_q >= last_pos);
  assign emit         = cmd_i.acc_step && row_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      slot_q  <= '0;
      ended_q <= 1'b0;
      row_q   <= '0;
    end else if (cmd_i.acc_step) begin
      if (row_done) begin
        acc_q   <= '0;
        slot_q  <= '0;
        ended_q <= 1'b0;
        row_q   <= (row_q >= count_m1) ? '0 : row_q + RowIdxW'(1);
      end else begin
        acc_q   <= acc_new;
        slot_q  <= slot_q + SlotW'(1);
        ended_q <= ended_q || sentinel_hit;
      end
    end
  end

  // Result register.
  logic                      out_valid_q;
  logic [RowIdxW-1:0]        row_index_q;
  logic signed [RowSumW-1:0] row_sum_q;
  logic                      last_row_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      row_index_q <= row_q;
      row_sum_q   <= RowSumW'($signed(acc_new));
      last_row_q  <= (row_q == count_m1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = row_index_q;
  assign row_sum_o   = row_sum_q;
  assign last_row_o  = last_row_q;

  // A finished row leaves a clean accumulator and slot count behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (slot_q == '0) && (acc_q == '0) && !ended_q)
    else $error("row state not cleared after a result");

  // Every result raises the result valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("result lost on emit");

  // A result beat that is held back keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=>
      (out_valid_q && $stable(row_index_q) && $stable(row_sum_q) && $stable(last_row_q)))
    else $error("result beat changed while waiting");

endmodule

FILE: rtl/ell_sparse_matrix_vector_multiply_core.sv
// ELLPACK sparse matrix times dense vector, integer form. A load beat
// (command 0) writes one vector element. A matrix slot beat (command 1)
// passes through the beat itself with the vector store read, three steps
// of a shared half-width multiplier forming the wrapped product, and the
// accumulate, and no new beat is taken until its accumulate is done; the
// accumulate waits while an earlier result still sits unclaimed in the
// result register. After the last slot of each row one result carries the
// row index, the wrapped sum and a final-row flag. Configuration writes are
// taken in every cycle. Depends on spmv_pkg, spmv_ctrl and spmv_datapath.
module ell_sparse_matrix_vector_multiply_core #(
  parameter int VECTOR_DEPTH = spmv_pkg::VectorDepthDef,
  parameter int VALUE_WIDTH  = spmv_pkg::ValueWidthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [spmv_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [spmv_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  command_i,
  input  logic signed [spmv_pkg::ColumnW-1:0]   column_i,
  input  logic signed [spmv_pkg::InValueW-1:0]  value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [spmv_pkg::RowIdxW-1:0]          row_index_o,
  output logic signed [spmv_pkg::RowSumW-1:0]   row_sum_o,
  output logic                                  last_row_o
);
  import spmv_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  spmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  spmv_datapath #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .command_i   (command_i),
    .column_i    (column_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_index_o (row_index_o),
    .row_sum_o   (row_sum_o),
    .last_row_o  (last_row_o)
  );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the ELLPACK sparse matrix-vector core.
// Depends on spmv_pkg and ell_sparse_matrix_vector_multiply_core; the expected
// row sums come from a behavioural copy of the core held in this file.
`timescale 1ns / 100ps

module tb_top;
  import spmv_pkg::*;

  localparam int VecDepth   = VectorDepthDef;
  localparam int StuckLimit = 2000;
  localparam int PhaseItems = 170;
  localparam int PhaseCount = 12;

  // One input beat and one row result.
  typedef struct packed {
    logic                cmd;
    logic [ColumnW-1:0]  col;
    logic [InValueW-1:0] val;
  } ell_beat_t;

  typedef struct packed {
    logic [RowIdxW-1:0] row_idx;
    logic [RowSumW-1:0] sum;
    logic               is_last;
  } row_result_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                command_i   = CmdLoad;
  logic [ColumnW-1:0]  column_i    = '0;
  logic [InValueW-1:0] value_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [RowIdxW-1:0]  row_index_o;
  logic [RowSumW-1:0]  row_sum_o;
  logic                last_row_o;

  ell_sparse_matrix_vector_multiply_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .column_i    (column_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_index_o (row_index_o),
    .row_sum_o   (row_sum_o),
    .last_row_o  (last_row_o)
  );

  // Beats waiting to be driven and row sums waiting to come out.
  ell_beat_t   beat_q[$];
  row_result_t row_sum_q[$];

  // Predicted state of the core and its registers.
  logic [31:0]          vec_mem [VecDepth];
  logic [31:0]          acc;
  logic [SlotW-1:0]     slot_cnt;
  logic                 row_done;
  logic [RowIdxW-1:0]   row_cnt;
  logic [RowWidthW-1:0] cfg_width;
  logic [RowCountW-1:0] cfg_count;
  logic [SentinelW-1:0] cfg_sentinel;

  // Generator bookkeeping: which vector entries hold data, and where the
  // stream stands within the current row.
  bit loaded_map [VecDepth];
  int loaded_cols[$];
  int gen_pos;
  bit gen_ended;

  bit idle_en;
  bit in_beat;
  int in_gap;
  int out_stall;
  int stuck_cycles;
  int mismatches;
  int loads_seen;
  int slots_seen;
  int rows_checked;
  int final_rows;
  int settings_used;

  int preset_width [8] = '{1, 0, 64, 127, 8, 3, 2, 5};
  int preset_count [8] = '{1, 3, 5, 0, 131071, 65536, 7, 4};
  int preset_sent  [8] = '{0, 1023, -1, 512, -1, 7, -1, 1023};

  // Work out what one accepted beat does to the row state.
  task automatic predict_row_sum(input logic cmd, input logic [ColumnW-1:0] col,
                                 input logic [31:0] val);
    int          addr;
    int          eff_width;
    int          eff_count;
    bit          in_range;
    row_result_t res;
    addr     = int'($signed(col));
    in_range = (addr >= 0) && (addr < VecDepth);
    if (cmd == CmdLoad) begin
      if (in_range) vec_mem[addr] = val;
      return;
    end
    eff_width = (cfg_width == 0) ? 1 : (cfg_width > 64) ? 64 : int'(cfg_width);
    if (!row_done) begin
      if (col == cfg_sentinel) row_done = 1'b1;
      else if (in_range) acc = acc + val * vec_mem[addr];
    end
    if (int'(slot_cnt) >= eff_width - 1) begin
      eff_count = (cfg_count == 0 || cfg_count > 65536) ? 65536 : int'(cfg_count);
      res.row_idx = row_cnt;
      res.sum     = acc;
      res.is_last = (int'(row_cnt) == eff_count - 1);
      row_sum_q.push_back(res);
      if (int'(row_cnt) >= eff_count - 1) row_cnt = '0;
      else row_cnt = row_cnt + 1'b1;
      acc      = '0;
      slot_cnt = '0;
      row_done = 1'b0;
    end else begin
      slot_cnt = slot_cnt + 1'b1;
    end
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Register write, only issued while the core is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgRowWidth: cfg_width = data[RowWidthW-1:0];
      CfgRowCount: cfg_count = data;
      CfgSentinel: cfg_sentinel = data[SentinelW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input int w, input int c, input int s);
    write_reg(CfgRowWidth, 17'(w));
    write_reg(CfgRowCount, 17'(c));
    write_reg(CfgSentinel, {6'b0, 11'(s)});
    settings_used++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_load(input logic [ColumnW-1:0] col, input logic [31:0] val);
    int        addr;
    ell_beat_t b;
    addr = int'($signed(col));
    if (addr >= 0 && addr < VecDepth && !loaded_map[addr]) begin
      loaded_map[addr] = 1'b1;
      loaded_cols.push_back(addr);
    end
    b.cmd = CmdLoad;
    b.col = col;
    b.val = val;
    beat_q.push_back(b);
  endfunction

  function automatic void push_slot(input logic [ColumnW-1:0] col, input logic [31:0] val);
    int        last_pos;
    ell_beat_t b;
    last_pos = (cfg_width == 0) ? 0 : (cfg_width > 64) ? 63 : int'(cfg_width) - 1;
    if (!gen_ended && col == cfg_sentinel) gen_ended = 1'b1;
    if (gen_pos >= last_pos) begin
      gen_pos   = 0;
      gen_ended = 1'b0;
    end else begin
      gen_pos++;
    end
    b.cmd = CmdSlot;
    b.col = col;
    b.val = val;
    beat_q.push_back(b);
  endfunction

  // Slot columns point at loaded entries, the sentinel or out-of-range columns, and
  // at any column once the row has hit its padding, so no unwritten entry is ever summed.
  function automatic logic [ColumnW-1:0] slot_column();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return cfg_sentinel;
    if (r < 16) return 11'($urandom_range(1024, 2047));
    if (r < 24 && gen_ended) return 11'($urandom);
    return 11'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
  endfunction

  task automatic gen_random(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 9) == 0) push_load(11'($urandom_range(1024, 2047)), rand_value());
        else push_load(11'($urandom_range(0, VecDepth - 1)), rand_value());
      end else begin
        push_slot(slot_column(), rand_value());
      end
    end
  endtask

  // Wait until every beat is in and every row sum is out, then let the
  // multiplier sequence of a trailing slot run out.
  task automatic wait_idle();
    while (beat_q.size() != 0 || in_valid_i || row_sum_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input driver: takes the next pending beat whenever the channel is free and no random gap is pending.
  always @(negedge clk_i) begin
    ell_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_beat) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (beat_q.size() > 0) begin
        nxt = beat_q.pop_front();
        command_i  <= nxt.cmd;
        column_i   <= nxt.col;
        value_i    <= nxt.val;
        in_valid_i <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side back-pressure in short bursts.
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_ready_i <= 1'b0;
      out_stall--;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      out_stall = $urandom_range(0, 4);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predicts on every input beat and checks every result beat.
  always @(posedge clk_i) begin
    row_result_t want;
    bit          cfg_beat;
    bit          out_beat;
    in_beat = 1'b0;
    if (rst_ni) begin
      in_beat  = in_valid_i && in_ready_o;
      out_beat = out_valid_o && out_ready_i;
      cfg_beat = cfg_valid_i && cfg_ready_o;
      if (in_beat) begin
        if (command_i == CmdLoad) loads_seen++;
        else slots_seen++;
        predict_row_sum(command_i, column_i, value_i);
      end
      if (out_beat) begin
        if (row_sum_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected row result, expected none, actual row %0d sum %0d",
                   $time, row_index_o, $signed(row_sum_o));
        end else begin
          want = row_sum_q.pop_front();
          rows_checked++;
          if (want.is_last) final_rows++;
          check_field("row_index", want.row_idx, row_index_o);
          check_field("row_sum", $signed(want.sum), $signed(row_sum_o));
          check_field("last_row", want.is_last, last_row_o);
        end
      end
      if (in_beat || out_beat || cfg_beat) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  // Watchdog on cycles without any beat.
  initial begin
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("%0t ns: no beat for %0d cycles, run stopped", $time, StuckLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int w;
    int c;
    int s;
    acc          = '0;
    slot_cnt     = '0;
    row_done     = 1'b0;
    row_cnt      = '0;
    cfg_width    = 7'd8;
    cfg_count    = 17'd1;
    cfg_sentinel = 11'h7FF;
    idle_en      = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: narrow rows, value extremes, padding, stray columns.
    apply_setting(4, 2, -1);
    push_load(11'd0, 32'h7FFF_FFFF);
    push_load(11'd1023, 32'h8000_0000);
    push_load(11'd1, 32'hFFFF_FFFF);
    push_load(11'd2, 32'd1);
    push_load(11'h7FF, 32'h1234_5678);
    push_load(11'h400, 32'hDEAD_BEEF);
    // A full row with a load slipped in half way.
    push_slot(11'd0, 32'd2);
    push_slot(11'd1023, 32'hFFFF_FFFF);
    push_load(11'd5, 32'd9);
    push_slot(11'd1, 32'h8000_0000);
    push_slot(11'd2, 32'd7);
    // Padding in the second slot; the rest of the row is skipped.
    push_slot(11'd2, 32'd5);
    push_slot(11'h7FF, 32'd9);
    push_slot(11'd0, 32'd3);
    push_slot(11'd1023, 32'd4);
    // Negative columns add nothing but still take a slot.
    push_slot(11'h7FB, 32'd100);
    push_slot(11'h400, 32'd7);
    push_slot(11'd0, 32'hFFFF_FFFF);
    push_slot(11'd1023, 32'd2);
    wait_idle();
    // Narrowing the row while two slots are already in.
    push_slot(11'd5, 32'd3);
    push_slot(11'd1, 32'd11);
    wait_idle();
    write_reg(CfgRowWidth, 17'd2);
    push_slot(11'd2, 32'h7FFF_FFFF);
    wait_idle();

    // Random part, each phase under its own register setting.
    for (int p = 0; p < PhaseCount; p++) begin
      idle_en = (p < PhaseCount - 2);
      if (p < 8) begin
        w = preset_width[p];
        c = preset_count[p];
        s = preset_sent[p];
      end else begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        c = $urandom_range(1, 20);
        s = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 1023);
      end
      apply_setting(w, c, s);
      gen_random(PhaseItems);
      wait_idle();
    end

    $display("Run covered %0d vector loads and %0d matrix slots under %0d register settings.",
             loads_seen, slots_seen, settings_used);
    $display("%0d row sums compared, %0d of them flagged as the final row.",
             rows_checked, final_rows);
    if (mismatches == 0 && row_sum_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
